[rtl/core/ssfd_pkg.sv]
// types, codes and constants shared by the stuffed frame deframer core
// no dependencies
package ssfd_pkg;

  // link format
  localparam logic [7:0] SYNC_BYTE         = 8'h1b;
  localparam logic [2:0] TYPE_SUPERVISORY  = 3'd1;
  localparam int unsigned FRAME_OVERHEAD   = 6;
  localparam int unsigned FIRST_PAYLOAD    = 4;
  localparam int unsigned DEF_MAX_FRAME_BYTES = 255 + 3;
  localparam int unsigned DEF_QUEUE_DEPTH  = 4;

  // result kinds
  typedef enum logic [2:0] {
    EV_PAYLOAD    = 3'd0,
    EV_GOOD_FRAME = 3'd1,
    EV_CSUM_ERR   = 3'd2,
    EV_SYNC_EXP   = 3'd3,
    EV_UNEXP_SYNC = 3'd4,
    EV_TOO_LONG   = 3'd5
  } ev_kind_e;

  // one classified request between front and back
  typedef struct packed {
    ev_kind_e   kind;
    logic [7:0] payload_byte;
    logic [4:0] station_address;
    logic [2:0] frame_type;
    logic [6:0] sequence_number;
    logic       retry_flag;
    logic [7:0] payload_length;
    logic       supervisory;
  } ev_t;

endpackage

[rtl/core/ssfd_front.sv]
// front end: hunts sync, destuffs, tracks position and sum, classifies bytes
// depends on ssfd_pkg
module ssfd_front import ssfd_pkg::*; #(
  parameter int unsigned MAX_FRAME_BYTES = DEF_MAX_FRAME_BYTES
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       accept_i,
  input  logic [7:0] in_byte_i,
  output logic       ev_valid_o,
  output ev_t        ev_o
);

  localparam logic [8:0] MaxTotal = 9'(MAX_FRAME_BYTES);

  logic [8:0] pos_q, pos_d;
  logic [8:0] total_q, total_d;
  logic       esc_q, esc_d;
  logic [7:0] sum_q, sum_d;
  logic [7:0] route_q, route_d;
  logic [7:0] ctrl_q, ctrl_d;
  logic [7:0] len_q, len_d;

  logic       is_sync;
  logic [8:0] len_total;
  logic [9:0] pos_next;
  logic [8:0] payload_end;
  logic       sup;

  assign is_sync     = (in_byte_i == SYNC_BYTE);
  assign len_total   = {1'b0, in_byte_i} + 9'(FRAME_OVERHEAD);
  assign pos_next    = {1'b0, pos_q} + 10'd1;
  assign payload_end = {1'b0, len_q} + 9'(FIRST_PAYLOAD);
  assign sup         = (route_q[7:5] == TYPE_SUPERVISORY);

  // byte classification and frame state update
  always_comb begin
    pos_d      = pos_q;
    total_d    = total_q;
    esc_d      = esc_q;
    sum_d      = sum_q;
    route_d    = route_q;
    ctrl_d     = ctrl_q;
    len_d      = len_q;
    ev_valid_o = 1'b0;
    ev_o       = '0;
    ev_o.kind  = EV_PAYLOAD;
    if (accept_i) begin
      if (pos_q == 9'd0) begin
        if (!is_sync) begin
          ev_valid_o = 1'b1;
          ev_o.kind  = EV_SYNC_EXP;
        end else begin
          esc_d = 1'b0;
          sum_d = '0;
          pos_d = 9'd1;
        end
      end else if (pos_q == 9'd1) begin
        if (is_sync) begin
          pos_d      = '0;
          ev_valid_o = 1'b1;
          ev_o.kind  = EV_UNEXP_SYNC;
        end else begin
          esc_d   = 1'b0;
          route_d = in_byte_i;
          sum_d   = sum_q + in_byte_i;
          pos_d   = 9'd2;
        end
      end else if (is_sync && !esc_q) begin
        // escape marker, dropped
        esc_d = 1'b1;
      end else begin
        esc_d = 1'b0;
        if (pos_q == 9'd2) begin
          ctrl_d = in_byte_i;
          sum_d  = sum_q + in_byte_i;
          pos_d  = 9'd3;
        end else if (pos_q == 9'd3) begin
          if (len_total > MaxTotal) begin
            pos_d      = '0;
            ev_valid_o = 1'b1;
            ev_o.kind  = EV_TOO_LONG;
          end else begin
            len_d   = in_byte_i;
            total_d = len_total;
            sum_d   = sum_q + in_byte_i;
            pos_d   = 9'd4;
          end
        end else if (pos_next >= {1'b0, total_q}) begin
          // trailing byte closes the frame
          pos_d      = '0;
          ev_valid_o = 1'b1;
          if (sum_q != 8'd0) begin
            ev_o.kind = EV_CSUM_ERR;
          end else begin
            ev_o.kind            = EV_GOOD_FRAME;
            ev_o.station_address = route_q[4:0];
            ev_o.frame_type      = route_q[7:5];
            ev_o.sequence_number = ctrl_q[6:0];
            ev_o.retry_flag      = ctrl_q[7];
            ev_o.payload_length  = len_q;
            ev_o.supervisory     = sup;
          end
        end else begin
          sum_d = sum_q + in_byte_i;
          pos_d = pos_next[8:0];
          if (pos_q < payload_end) begin
            ev_valid_o        = 1'b1;
            ev_o.kind         = EV_PAYLOAD;
            ev_o.payload_byte = in_byte_i;
            ev_o.supervisory  = sup;
          end
        end
      end
    end
  end

  // frame state registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q   <= '0;
      total_q <= '0;
      esc_q   <= 1'b0;
      sum_q   <= '0;
      route_q <= '0;
      ctrl_q  <= '0;
      len_q   <= '0;
    end else begin
      pos_q   <= pos_d;
      total_q <= total_d;
      esc_q   <= esc_d;
      sum_q   <= sum_d;
      route_q <= route_d;
      ctrl_q  <= ctrl_d;
      len_q   <= len_d;
    end
  end

  // payload only comes from inside a frame body
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ev_valid_o && ev_o.kind == EV_PAYLOAD) |-> (pos_q >= 9'(FIRST_PAYLOAD)))
    else $error("payload request outside frame body");

  // an accepted frame length never exceeds the limit
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pos_q >= 9'(FIRST_PAYLOAD)) |-> (total_q <= MaxTotal))
    else $error("frame total above limit");

endmodule

[rtl/core/ssfd_queue.sv]
// short request queue decoupling front and back
// depends on ssfd_pkg
module ssfd_queue import ssfd_pkg::*; #(
  parameter int unsigned DEPTH = DEF_QUEUE_DEPTH
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic wr_i,
  input  ev_t  wr_data_i,
  output logic full_o,
  input  logic rd_i,
  output logic valid_o,
  output ev_t  rd_data_o
);

  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);
  localparam logic [AW-1:0] LastIdx = AW'(DEPTH - 1);

  ev_t           mem_q [DEPTH];
  logic [AW-1:0] wptr_q, rptr_q;
  logic [CW-1:0] cnt_q;
  logic          do_wr, do_rd;

  assign full_o    = (cnt_q == CW'(DEPTH));
  assign valid_o   = (cnt_q != '0);
  assign rd_data_o = mem_q[rptr_q];
  assign do_wr     = wr_i && !full_o;
  assign do_rd     = rd_i && valid_o;

  // storage, no reset needed
  always_ff @(posedge clk_i) begin
    if (do_wr) begin
      mem_q[wptr_q] <= wr_data_i;
    end
  end

  // pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      if (do_wr) begin
        wptr_q <= (wptr_q == LastIdx) ? '0 : wptr_q + AW'(1);
      end
      if (do_rd) begin
        rptr_q <= (rptr_q == LastIdx) ? '0 : rptr_q + AW'(1);
      end
      if (do_wr && !do_rd) begin
        cnt_q <= cnt_q + CW'(1);
      end else if (do_rd && !do_wr) begin
        cnt_q <= cnt_q - CW'(1);
      end
    end
  end

  // fill count stays within depth
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CW'(DEPTH))
    else $error("queue count overflow");

  // pointers agree with count when empty
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cnt_q == '0) |-> (wptr_q == rptr_q))
    else $error("queue pointers out of step");

endmodule

[rtl/core/ssfd_back.sv]
// back end: supervisory filter, result register and pop handshake
// depends on ssfd_pkg
module ssfd_back import ssfd_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic cfg_we_i,
  input  logic cfg_show_supervisory_i,
  input  logic req_valid_i,
  input  ev_t  req_i,
  output logic req_take_o,
  input  logic pop_i,
  output logic empty_o,
  output ev_t  res_o
);

  logic show_q;
  logic out_valid_q, out_valid_d;
  ev_t  out_q;
  logic drop, can_load, load;

  assign drop       = req_i.supervisory && !show_q;
  assign can_load   = !out_valid_q || pop_i;
  assign load       = req_valid_i && !drop && can_load;
  assign req_take_o = req_valid_i && (drop || can_load);
  assign empty_o    = !out_valid_q;
  assign res_o      = out_q;

  // result register occupancy
  always_comb begin
    out_valid_d = out_valid_q;
    if (load) begin
      out_valid_d = 1'b1;
    end else if (pop_i) begin
      out_valid_d = 1'b0;
    end
  end

  // configuration and control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      show_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        show_q <= cfg_show_supervisory_i;
      end
      out_valid_q <= out_valid_d;
    end
  end

  // result payload
  always_ff @(posedge clk_i) begin
    if (load) begin
      out_q <= req_i;
    end
  end

  // a hidden supervisory request never reaches the output
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    load |=> !(out_q.supervisory && !$past(show_q)))
    else $error("suppressed request reached output");

  // a loaded request is presented in the next cycle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    load |=> out_valid_q)
    else $error("loaded result not presented");

endmodule

[rtl/core/sync_stuffed_frame_deframer_core.sv]
// top level of the stuffed frame deframer: front, request queue, back
// depends on ssfd_pkg, ssfd_front, ssfd_queue, ssfd_back
//
// Takes one received link byte per clock and returns at most one result per
// byte: a destuffed payload byte, a frame verdict with the header fields, or a
// framing error. A byte is taken at every edge with push high and full low,
// and full rises only when the result queue (QUEUE_DEPTH entries plus one
// output register) is filled by a stalled pop side, so while pop keeps up the
// sustained rate is one byte per cycle. When nothing waits ahead of a byte,
// it is classified and written into the queue at the accepting edge and then
// moves from the queue into the output register, which drives the outputs.
// Supervisory frames are filtered in the back end with the
// show_supervisory setting, which must be written while no result is
// outstanding.
module sync_stuffed_frame_deframer_core import ssfd_pkg::*; #(
  parameter int unsigned MAX_FRAME_BYTES = DEF_MAX_FRAME_BYTES,
  parameter int unsigned QUEUE_DEPTH     = DEF_QUEUE_DEPTH
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       cfg_we_i,
  input  logic       cfg_show_supervisory_i,
  input  logic       push,
  output logic       full,
  input  logic [7:0] in_byte_i,
  input  logic       pop,
  output logic       empty,
  output logic [2:0] event_kind_o,
  output logic [7:0] payload_byte_o,
  output logic [4:0] station_address_o,
  output logic [2:0] frame_type_o,
  output logic [6:0] sequence_number_o,
  output logic       retry_flag_o,
  output logic [7:0] payload_length_o
);

  logic accept;
  logic fr_valid;
  ev_t  fr_ev;
  logic q_valid, q_take;
  ev_t  q_ev;
  ev_t  res;

  assign accept = push && !full;

  // classifier
  ssfd_front #(
    .MAX_FRAME_BYTES(MAX_FRAME_BYTES)
  ) u_front (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .accept_i  (accept),
    .in_byte_i (in_byte_i),
    .ev_valid_o(fr_valid),
    .ev_o      (fr_ev)
  );

  // request queue
  ssfd_queue #(
    .DEPTH(QUEUE_DEPTH)
  ) u_queue (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .wr_i     (fr_valid),
    .wr_data_i(fr_ev),
    .full_o   (full),
    .rd_i     (q_take),
    .valid_o  (q_valid),
    .rd_data_o(q_ev)
  );

  // filter and result register
  ssfd_back u_back (
    .clk_i                 (clk_i),
    .rst_ni                (rst_ni),
    .cfg_we_i              (cfg_we_i),
    .cfg_show_supervisory_i(cfg_show_supervisory_i),
    .req_valid_i           (q_valid),
    .req_i                 (q_ev),
    .req_take_o            (q_take),
    .pop_i                 (pop),
    .empty_o               (empty),
    .res_o                 (res)
  );

  // result fields
  assign event_kind_o      = res.kind;
  assign payload_byte_o    = res.payload_byte;
  assign station_address_o = res.station_address;
  assign frame_type_o      = res.frame_type;
  assign sequence_number_o = res.sequence_number;
  assign retry_flag_o      = res.retry_flag;
  assign payload_length_o  = res.payload_length;

endmodule

[dv/tb_sync_stuffed_frame_deframer_core.sv]
`timescale 1ns / 100ps
// self-checking testbench for sync_stuffed_frame_deframer_core
// depends on ssfd_pkg and the deframer core rtl; link bytes in, predicted events checked out
module tb_sync_stuffed_frame_deframer_core import ssfd_pkg::*; ();

  localparam int unsigned MAX_BYTES     = DEF_MAX_FRAME_BYTES;
  localparam int unsigned DRAIN_CYCLES  = 16;
  localparam int unsigned SETTLE_LIMIT  = 20000;
  localparam int unsigned PHASE_BYTES   = 155;
  localparam int unsigned NUM_PHASES    = 8;
  localparam int unsigned WATCHDOG_NS   = 800000;

  // frame types other than supervisory
  localparam logic [2:0] TYPE_CMD = 3'd2;
  localparam logic [2:0] TYPE_ACK = 3'd3;
  localparam logic [2:0] TYPE_RSY = 3'd6;
  localparam logic [2:0] TYPE_NAK = 3'd7;

  typedef logic [7:0] byte_list_t[$];

  typedef struct packed {
    ev_kind_e   kind;
    logic [7:0] data;
    logic [4:0] addr;
    logic [2:0] ftype;
    logic [6:0] seq;
    logic       retry;
    logic [7:0] plen;
  } deframe_result_t;

  logic       clk_i                  = 1'b0;
  logic       rst_ni                 = 1'b0;
  logic       cfg_we_i               = 1'b0;
  logic       cfg_show_supervisory_i = 1'b0;
  logic       push                   = 1'b0;
  logic       full;
  logic [7:0] in_byte_i              = 8'h00;
  logic       pop                    = 1'b0;
  logic       empty;
  logic [2:0] event_kind_o;
  logic [7:0] payload_byte_o;
  logic [4:0] station_address_o;
  logic [2:0] frame_type_o;
  logic [6:0] sequence_number_o;
  logic       retry_flag_o;
  logic [7:0] payload_length_o;

  // stimulus and scoreboard
  byte_list_t      link_bytes;
  deframe_result_t expected_events[$];
  int unsigned     mismatches     = 0;
  int unsigned     send_idle_pct  = 0;
  int unsigned     recv_stall_pct = 0;
  bit              flushing       = 1'b0;

  // predictor state, mirrors the deframer after reset
  logic [8:0] frm_pos   = '0;
  logic [8:0] frm_total = '0;
  logic       esc_q     = 1'b0;
  logic [7:0] sum_q     = '0;
  logic [7:0] route_q   = '0;
  logic [7:0] ctrl_q    = '0;
  logic [7:0] len_q     = '0;
  logic       show_sup  = 1'b0;

  sync_stuffed_frame_deframer_core #(
    .MAX_FRAME_BYTES(MAX_BYTES)
  ) i_dut (
    .clk_i                 (clk_i),
    .rst_ni                (rst_ni),
    .cfg_we_i              (cfg_we_i),
    .cfg_show_supervisory_i(cfg_show_supervisory_i),
    .push                  (push),
    .full                  (full),
    .in_byte_i             (in_byte_i),
    .pop                   (pop),
    .empty                 (empty),
    .event_kind_o          (event_kind_o),
    .payload_byte_o        (payload_byte_o),
    .station_address_o     (station_address_o),
    .frame_type_o          (frame_type_o),
    .sequence_number_o     (sequence_number_o),
    .retry_flag_o          (retry_flag_o),
    .payload_length_o      (payload_length_o)
  );

  // clock
  initial begin
    forever #2 clk_i = ~clk_i;
  end

  // watchdog
  initial begin
    #(WATCHDOG_NS);
    $display("FAILURE");
    $finish;
  end

  // predicted deframer behavior for one link byte, returns 1 when an event is due
  function automatic bit deframe_byte(input logic [7:0] c, output deframe_result_t res);
    logic [8:0] p;
    logic       hide;
    p    = frm_pos;
    res  = '0;
    hide = (route_q[7:5] == TYPE_SUPERVISORY) && !show_sup;
    // hunting, double sync and escape handling
    if (p == 0) begin
      if (c != SYNC_BYTE) begin
        res.kind = EV_SYNC_EXP;
        return 1'b1;
      end
    end else if (p == 1) begin
      if (c == SYNC_BYTE) begin
        frm_pos  = '0;
        res.kind = EV_UNEXP_SYNC;
        return 1'b1;
      end
    end else if (c == SYNC_BYTE && !esc_q) begin
      esc_q = 1'b1;
      return 1'b0;
    end
    esc_q = 1'b0;
    // header bytes
    if (p == 0) begin
      sum_q   = '0;
      frm_pos = 9'd1;
      return 1'b0;
    end
    if (p == 1) begin
      route_q = c;
      sum_q   = sum_q + c;
      frm_pos = 9'd2;
      return 1'b0;
    end
    if (p == 2) begin
      ctrl_q  = c;
      sum_q   = sum_q + c;
      frm_pos = 9'd3;
      return 1'b0;
    end
    if (p == 3) begin
      if (c + FRAME_OVERHEAD > MAX_BYTES) begin
        frm_pos  = '0;
        res.kind = EV_TOO_LONG;
        return 1'b1;
      end
      len_q     = c;
      frm_total = 9'(c + FRAME_OVERHEAD);
      sum_q     = sum_q + c;
      frm_pos   = 9'd4;
      return 1'b0;
    end
    // trailing byte closes the frame
    if (p + 1 >= frm_total) begin
      frm_pos = '0;
      if (sum_q != 0) begin
        res.kind = EV_CSUM_ERR;
        return 1'b1;
      end
      if (hide) return 1'b0;
      res.kind  = EV_GOOD_FRAME;
      res.addr  = route_q[4:0];
      res.ftype = route_q[7:5];
      res.seq   = ctrl_q[6:0];
      res.retry = ctrl_q[7];
      res.plen  = len_q;
      return 1'b1;
    end
    // payload and checksum bytes
    sum_q   = sum_q + c;
    frm_pos = 9'(p + 1);
    if (p < FIRST_PAYLOAD + len_q && !hide) begin
      res.kind = EV_PAYLOAD;
      res.data = c;
      return 1'b1;
    end
    return 1'b0;
  endfunction

  task automatic check_field(input string name, input logic [7:0] want, input logic [7:0] got);
    if (got !== want) begin
      $error("%s mismatch: expected 0x%0h, actual 0x%0h", name, want, got);
      mismatches++;
    end
  endtask

  // one link byte, stuffed with a leading sync when it equals the sync byte
  task automatic put_stuffed(input logic [7:0] b);
    if (b == SYNC_BYTE) link_bytes.push_back(SYNC_BYTE);
    link_bytes.push_back(b);
  endtask

  // whole frame: sync, header, payload, checksum, trailer
  task automatic add_frame(input logic [7:0] route, input logic [7:0] ctrl,
                           input byte_list_t body, input bit corrupt);
    logic [7:0] csum;
    csum = route + ctrl + 8'(body.size());
    foreach (body[i]) csum = csum + body[i];
    csum = -csum;
    if (corrupt) csum = csum + 8'($urandom_range(1, 255));
    link_bytes.push_back(SYNC_BYTE);
    put_stuffed(route);
    put_stuffed(ctrl);
    put_stuffed(8'(body.size()));
    foreach (body[i]) put_stuffed(body[i]);
    put_stuffed(csum);
    put_stuffed(8'($urandom));
  endtask

  // random mix of frames, oversize headers, noise and broken frames
  task automatic gen_traffic(input int unsigned n_bytes);
    int unsigned start;
    int unsigned pick;
    int unsigned len;
    logic [7:0]  route;
    byte_list_t  body;
    start = link_bytes.size();
    while (link_bytes.size() - start < n_bytes) begin
      pick  = $urandom_range(99);
      route = 8'($urandom);
      if ($urandom_range(3) != 0) begin
        case ($urandom_range(4))
          0:       route[7:5] = TYPE_SUPERVISORY;
          1:       route[7:5] = TYPE_CMD;
          2:       route[7:5] = TYPE_ACK;
          3:       route[7:5] = TYPE_RSY;
          default: route[7:5] = TYPE_NAK;
        endcase
      end
      if (pick < 72) begin
        len = ($urandom_range(49) == 0) ? $urandom_range(200, 252) : $urandom_range(0, 8);
        body.delete();
        repeat (len) body.push_back(($urandom_range(9) == 0) ? SYNC_BYTE : 8'($urandom));
        add_frame(route, 8'($urandom), body, $urandom_range(99) < 12);
      end else if (pick < 80) begin
        link_bytes.push_back(SYNC_BYTE);
        put_stuffed(route);
        put_stuffed(8'($urandom));
        put_stuffed(8'($urandom_range(MAX_BYTES - FRAME_OVERHEAD + 1, 255)));
      end else if (pick < 88) begin
        repeat ($urandom_range(1, 4))
          link_bytes.push_back(($urandom_range(3) == 0) ? SYNC_BYTE : 8'($urandom));
      end else if (pick < 93) begin
        link_bytes.push_back(SYNC_BYTE);
        link_bytes.push_back(SYNC_BYTE);
      end else begin
        link_bytes.push_back(SYNC_BYTE);
        repeat ($urandom_range(1, 6)) put_stuffed(8'($urandom));
      end
    end
  endtask

  // wait for all requests taken and all events seen, then let the pipeline empty
  task automatic settle();
    int unsigned waited;
    waited = 0;
    @(negedge clk_i);
    while ((link_bytes.size() != 0 || push || expected_events.size() != 0) &&
           waited < SETTLE_LIMIT) begin
      @(negedge clk_i);
      waited++;
    end
    if (link_bytes.size() != 0 || push || expected_events.size() != 0) begin
      $error("events still outstanding: %0d", expected_events.size());
      mismatches++;
    end
    flushing = 1'b1;
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    flushing = 1'b0;
  endtask

  task automatic set_show_supervisory(input logic value);
    @(posedge clk_i);
    cfg_we_i               <= 1'b1;
    cfg_show_supervisory_i <= value;
    show_sup                = value;
    @(posedge clk_i);
    cfg_we_i               <= 1'b0;
  endtask

  // request driver with prediction at acceptance
  always @(posedge clk_i) begin : driver
    deframe_result_t got;
    if (!rst_ni) begin
      push <= 1'b0;
    end else begin
      if (push && !full) begin
        if (deframe_byte(in_byte_i, got)) expected_events.push_back(got);
      end
      if (!(push && full)) begin
        if (link_bytes.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          push      <= 1'b1;
          in_byte_i <= link_bytes.pop_front();
        end else begin
          push <= 1'b0;
        end
      end
    end
  end

  // result monitor and checker
  always @(posedge clk_i) begin : monitor
    deframe_result_t want;
    if (!rst_ni) begin
      pop <= 1'b0;
    end else begin
      if (pop && !empty) begin
        if (expected_events.size() == 0) begin
          $error("event with no request outstanding: kind %0d", event_kind_o);
          mismatches++;
        end else begin
          want = expected_events.pop_front();
          check_field("event_kind", 8'(want.kind), 8'(event_kind_o));
          check_field("payload_byte", want.data, payload_byte_o);
          check_field("station_address", 8'(want.addr), 8'(station_address_o));
          check_field("frame_type", 8'(want.ftype), 8'(frame_type_o));
          check_field("sequence_number", 8'(want.seq), 8'(sequence_number_o));
          check_field("retry_flag", 8'(want.retry), 8'(retry_flag_o));
          check_field("payload_length", want.plen, payload_length_o);
        end
      end
      pop <= flushing || ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // reset, directed cases, then random phases
  initial begin
    byte_list_t body;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;

    // hunting on both extremes of a non-sync byte
    link_bytes.push_back(8'h00);
    link_bytes.push_back(8'hff);
    // double sync
    link_bytes.push_back(SYNC_BYTE);
    link_bytes.push_back(SYNC_BYTE);
    // oversize length
    link_bytes.push_back(SYNC_BYTE);
    link_bytes.push_back({TYPE_NAK, 5'd0});
    link_bytes.push_back(8'h00);
    link_bytes.push_back(8'hfd);
    // escaped sync data followed by a new escape, all-ones address and control
    body.delete();
    body.push_back(SYNC_BYTE);
    body.push_back(SYNC_BYTE);
    add_frame({TYPE_CMD, 5'h1f}, 8'hff, body, 1'b0);
    // bad checksum on a supervisory frame is still reported
    body.delete();
    add_frame({TYPE_SUPERVISORY, 5'h00}, 8'h00, body, 1'b1);
    // good supervisory frame stays hidden with the reset setting
    body.push_back(8'h00);
    add_frame({TYPE_SUPERVISORY, 5'h1f}, 8'h7f, body, 1'b0);
    settle();

    for (int unsigned ph = 0; ph < NUM_PHASES; ph++) begin
      set_show_supervisory(~ph[0]);
      case (ph / 2)
        0:       begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1:       begin send_idle_pct = 56; recv_stall_pct = 0;  end
        2:       begin send_idle_pct = 0;  recv_stall_pct = 56; end
        default: begin send_idle_pct = 14; recv_stall_pct = 14; end
      endcase
      // longest legal frame once
      if (ph == 0) begin
        body.delete();
        repeat (MAX_BYTES - FRAME_OVERHEAD) body.push_back(8'($urandom));
        add_frame({TYPE_ACK, 5'h0a}, 8'h80, body, 1'b0);
      end
      gen_traffic(PHASE_BYTES);
      settle();
    end

    if (mismatches == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
